>>> src/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared widths, opcodes and constants of the vertex transform block.
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // product width, homogeneous sum width and magnitude width
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int SUM_W  = 2 * VALUE_WIDTH + 2;
    localparam int MAG_W  = 2 * VALUE_WIDTH;

    // divider pipeline: magnitude, range check, one stage per quotient bit, clamp
    localparam int DIV_LAT = VALUE_WIDTH + 3;

    localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_MAG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] ONE_Q   = (FRAC_BITS < VALUE_WIDTH - 1) ?
        VALUE_WIDTH'(64'd1 << FRAC_BITS) : MAX_POS;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } opcode_t;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [SUM_W-1:0]       hsum_t;

endpackage

>>> src/vtp_in_if.sv
// ----------------------------------------------------------------------------
// vtp_in_if
// Input channel: matrix loads and vertices.
// ----------------------------------------------------------------------------
interface vtp_in_if
    import vtp_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [1:0]                    row_index;
    logic [1:0]                    col_index;
    logic signed [VALUE_WIDTH-1:0] element_value;
    logic signed [VALUE_WIDTH-1:0] vert_x;
    logic signed [VALUE_WIDTH-1:0] vert_y;
    logic signed [VALUE_WIDTH-1:0] vert_z;

    modport source (output valid, opcode, row_index, col_index, element_value,
                    vert_x, vert_y, vert_z, input ready);
    modport sink   (input valid, opcode, row_index, col_index, element_value,
                    vert_x, vert_y, vert_z, output ready);
endinterface

>>> src/vtp_out_if.sv
// ----------------------------------------------------------------------------
// vtp_out_if
// Output channel: projected vertices and flags.
// ----------------------------------------------------------------------------
interface vtp_out_if
    import vtp_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] out_x;
    logic signed [VALUE_WIDTH-1:0] out_y;
    logic signed [VALUE_WIDTH-1:0] out_z;
    logic                          w_zero;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface

>>> src/vtp_dot_lane.sv
// ----------------------------------------------------------------------------
// vtp_dot_lane
// One matrix column: three products, then the homogeneous sum.
// ----------------------------------------------------------------------------
module vtp_dot_lane
    import vtp_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  value_t vx,
    input  value_t vy,
    input  value_t vz,
    input  value_t m0,
    input  value_t m1,
    input  value_t m2,
    input  value_t m3,
    output hsum_t  h
);

    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    value_t                   m3_reg;
    hsum_t                    h_reg;
    hsum_t                    h_next;

    always_comb
    begin
        h_next = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg)
               + (SUM_W'(m3_reg) <<< FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= vx * m0;
            p1_reg <= vy * m1;
            p2_reg <= vz * m2;
            m3_reg <= m3;
            h_reg  <= h_next;
        end
    end

    assign h = h_reg;

endmodule

>>> src/vtp_div_lane.sv
// ----------------------------------------------------------------------------
// vtp_div_lane
// Pipelined signed fixed-point divide h / w with clamp, one quotient bit a stage.
// ----------------------------------------------------------------------------
module vtp_div_lane
    import vtp_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  hsum_t  h,
    input  hsum_t  hw,
    output value_t q,
    output logic   sat
);

    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int HI_W  = NUM_W - VALUE_WIDTH;
    localparam int CMP_W = (NUM_W > MAG_W) ? NUM_W : MAG_W;

    // magnitude stage
    logic [MAG_W-1:0] mh_reg;
    logic [MAG_W-1:0] mw_reg;
    logic             neg_reg;
    hsum_t            abs_h;
    hsum_t            abs_w;

    // divide stages: index 0 is the range check output
    logic [MAG_W-1:0]       rem_reg [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] lo_reg  [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] quo_reg [VALUE_WIDTH+1];
    logic [MAG_W-1:0]       d_reg   [VALUE_WIDTH+1];
    logic                   sg_reg  [VALUE_WIDTH+1];
    logic                   ov_reg  [VALUE_WIDTH+1];

    logic [NUM_W-1:0] num;
    logic [HI_W-1:0]  num_hi;

    value_t                 q_reg;
    value_t                 q_next;
    logic                   sat_reg;
    logic                   sat_next;
    logic [VALUE_WIDTH-1:0] limit;
    logic [VALUE_WIDTH-1:0] mag;

    always_comb
    begin
        abs_h  = h[SUM_W-1]  ? -h  : h;
        abs_w  = hw[SUM_W-1] ? -hw : hw;
        num    = {mh_reg, {FRAC_BITS{1'b0}}};
        num_hi = num[NUM_W-1:VALUE_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mh_reg  <= abs_h[MAG_W-1:0];
            mw_reg  <= abs_w[MAG_W-1:0];
            neg_reg <= h[SUM_W-1] ^ hw[SUM_W-1];
            // quotient needs more than VALUE_WIDTH bits: clamp
            ov_reg[0]  <= CMP_W'(num_hi) >= CMP_W'(mw_reg);
            rem_reg[0] <= MAG_W'(num_hi);
            lo_reg[0]  <= num[VALUE_WIDTH-1:0];
            quo_reg[0] <= '0;
            d_reg[0]   <= mw_reg;
            sg_reg[0]  <= neg_reg;
        end
    end

    for (genvar k = 0; k < VALUE_WIDTH; k++)
    begin : g_step
        logic [MAG_W:0] trial;
        logic           take;

        always_comb
        begin
            trial = {rem_reg[k], lo_reg[k][VALUE_WIDTH-1]};
            take  = trial >= {1'b0, d_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? MAG_W'(trial - {1'b0, d_reg[k]}) : trial[MAG_W-1:0];
                lo_reg[k+1]  <= lo_reg[k] << 1;
                quo_reg[k+1] <= {quo_reg[k][VALUE_WIDTH-2:0], take};
                d_reg[k+1]   <= d_reg[k];
                sg_reg[k+1]  <= sg_reg[k];
                ov_reg[k+1]  <= ov_reg[k];
            end
        end
    end

    always_comb
    begin
        limit    = sg_reg[VALUE_WIDTH] ? MIN_MAG : MAX_POS;
        sat_next = ov_reg[VALUE_WIDTH] || (quo_reg[VALUE_WIDTH] > limit);
        mag      = sat_next ? limit : quo_reg[VALUE_WIDTH];
        q_next   = sg_reg[VALUE_WIDTH] ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= q_next;
            sat_reg <= sat_next;
        end
    end

    assign q   = q_reg;
    assign sat = sat_reg;

endmodule

>>> src/vertex_transform_perspective_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_top
// 4x4 row-vector transform of Q16.16 vertices with perspective divide.
// ----------------------------------------------------------------------------
// Throughput: one word a cycle while the output word is not held; the divider spends one stage on each
// quotient bit, so its depth sets the latency, not the rate.
// A load word updates the matrix at acceptance and gives no result.
// Reset: matrix returns to identity, pipeline valids clear.
module vertex_transform_perspective_top
    import vtp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vtp_in_if.sink    vtx_in,
    vtp_out_if.source vtx_out
);

    value_t mat_reg [16];
    logic   en;
    logic   accept;
    logic   v1_reg;
    logic   v2_reg;
    logic   vld_reg [DIV_LAT];
    logic   wz_reg  [DIV_LAT];
    hsum_t  h [4];
    value_t q [3];
    logic   s [3];

    logic   out_valid_reg;
    value_t ox_reg;
    value_t oy_reg;
    value_t oz_reg;
    logic   wz_out_reg;
    logic   sat_out_reg;

    // advance everything unless the output word is held
    assign en            = !out_valid_reg || vtx_out.ready;
    assign vtx_in.ready  = en;
    assign accept        = vtx_in.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? ONE_Q : '0;
        end
        else if (accept && vtx_in.opcode == OP_LOAD)
        begin
            mat_reg[{vtx_in.row_index, vtx_in.col_index}] <= vtx_in.element_value;
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_dot
        vtp_dot_lane u_dot (
            .clk (clk),
            .en  (en),
            .vx  (vtx_in.vert_x),
            .vy  (vtx_in.vert_y),
            .vz  (vtx_in.vert_z),
            .m0  (mat_reg[j]),
            .m1  (mat_reg[4 + j]),
            .m2  (mat_reg[8 + j]),
            .m3  (mat_reg[12 + j]),
            .h   (h[j])
        );
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_div
        vtp_div_lane u_div (
            .clk (clk),
            .en  (en),
            .h   (h[j]),
            .hw  (h[3]),
            .q   (q[j]),
            .sat (s[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
                vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg     <= accept && vtx_in.opcode == OP_XFORM;
            v2_reg     <= v1_reg;
            vld_reg[0] <= v2_reg;
            for (int i = 1; i < DIV_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wz_reg[0] <= (h[3] == '0);
            for (int i = 1; i < DIV_LAT; i++)
                wz_reg[i] <= wz_reg[i-1];
            // merge: zero w overrides the lane results
            wz_out_reg  <= wz_reg[DIV_LAT-1];
            ox_reg      <= wz_reg[DIV_LAT-1] ? '0 : q[0];
            oy_reg      <= wz_reg[DIV_LAT-1] ? '0 : q[1];
            oz_reg      <= wz_reg[DIV_LAT-1] ? '0 : q[2];
            sat_out_reg <= !wz_reg[DIV_LAT-1] && (s[0] || s[1] || s[2]);
        end
    end

    assign vtx_out.valid     = out_valid_reg;
    assign vtx_out.out_x     = ox_reg;
    assign vtx_out.out_y     = oy_reg;
    assign vtx_out.out_z     = oz_reg;
    assign vtx_out.w_zero    = wz_out_reg;
    assign vtx_out.saturated = sat_out_reg;

endmodule
